### rtl/core/mlsq_pkg.sv
package mlsq_pkg;

  localparam int NUM_LISTS  = 16;
  localparam int POOL_DEPTH = 64;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W  = 2;
  localparam int ID_W  = 4;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;

  localparam int LIST_IW  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int ID_EXT_W = ((LIST_IW > ID_W) ? LIST_IW : ID_W) + 1;
  localparam int PTR_W    = $clog2(POOL_DEPTH);
  localparam int CNT_W    = $clog2(POOL_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_NO_LIST = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic latch;
    logic eval;
    logic mem;
    logic link;
  } cmd_t;

  typedef struct packed {
    logic need_mem;
    logic need_link;
  } sts_t;

endpackage

### rtl/core/mlsq_ram.sv
module mlsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/mlsq_ctrl.sv
module mlsq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mlsq_pkg::sts_t sts,
  output mlsq_pkg::cmd_t cmd,
  output logic           busy,
  output logic           out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_MEM,
    S_LINK
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (sts.need_mem) begin
            state_r     <= S_MEM;
            out_valid_r <= 1'b0;
          end else begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_MEM: begin
          if (sts.need_link) begin
            state_r     <= S_LINK;
            out_valid_r <= 1'b0;
          end else begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_LINK: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.latch = (state_r == S_IDLE) && start;
    cmd.eval  = (state_r == S_EVAL);
    cmd.mem   = (state_r == S_MEM);
    cmd.link  = (state_r == S_LINK);
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/core/mlsq_dp.sv
module mlsq_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mlsq_pkg::cmd_t                        cmd,
  output mlsq_pkg::sts_t                        sts,
  input  logic [mlsq_pkg::OP_W-1:0]             in_op,
  input  logic [mlsq_pkg::ID_W-1:0]             in_list_id,
  input  logic                                  in_make_stack,
  input  logic signed [mlsq_pkg::VAL_W-1:0]     in_push_value,
  output logic [mlsq_pkg::ST_W-1:0]             out_status,
  output logic signed [mlsq_pkg::VAL_W-1:0]     out_popped_value
);

  localparam int NL = mlsq_pkg::NUM_LISTS;
  localparam int PD = mlsq_pkg::POOL_DEPTH;
  localparam int DW = mlsq_pkg::DATA_WIDTH;
  localparam int PW = mlsq_pkg::PTR_W;
  localparam int CW = mlsq_pkg::CNT_W;
  localparam int IW = mlsq_pkg::LIST_IW;
  localparam int XW = mlsq_pkg::ID_EXT_W;

  logic [mlsq_pkg::OP_W-1:0] req_op_r;
  logic [IW-1:0]             req_idx_r;
  logic                      req_valid_r;
  logic                      req_stack_r;
  logic [DW-1:0]             req_val_r;

  logic          exists_r [NL];
  logic          stack_r  [NL];
  logic          items_r  [NL];
  logic [PW-1:0] head_r   [NL];
  logic [PW-1:0] tail_r   [NL];

  logic [PW-1:0] free_head_r;
  logic [CW-1:0] free_cnt_r;
  logic          link_vld_r [PD];

  logic [PW-1:0] e_r;
  logic [PW-1:0] prev_tail_r;
  logic [PW-1:0] rd_idx_r;
  logic          rd_vld_r;

  logic [mlsq_pkg::ST_W-1:0]  out_status_r;
  logic [mlsq_pkg::VAL_W-1:0] out_pop_r;

  logic [XW-1:0]     id_ext;
  logic [63:0]       push_ext;
  logic [63:0]       pop_ext;
  logic              cur_exists;
  logic              cur_stack;
  logic              cur_items;
  logic [PW-1:0]     cur_head;
  logic [PW-1:0]     cur_tail;
  mlsq_pkg::status_t st_comb;
  logic              is_push;
  logic              is_pop;
  logic              respond;
  logic [PW-1:0]     rd_addr;
  logic [PW-1:0]     link_rdata;
  logic [PW-1:0]     link_rd;
  logic              link_we;
  logic [PW-1:0]     link_waddr;
  logic [PW-1:0]     link_wdata;
  logic              val_we;
  logic [DW-1:0]     val_rdata;

  assign id_ext   = XW'(in_list_id);
  assign push_ext = 64'($unsigned(in_push_value));
  assign pop_ext  = 64'(val_rdata);

  assign cur_exists = req_valid_r && exists_r[req_idx_r];
  assign cur_stack  = stack_r[req_idx_r];
  assign cur_items  = items_r[req_idx_r];
  assign cur_head   = head_r[req_idx_r];
  assign cur_tail   = tail_r[req_idx_r];
  assign is_push    = (req_op_r == mlsq_pkg::OP_PUSH);
  assign is_pop     = (req_op_r == mlsq_pkg::OP_POP);

  always_comb begin
    case (req_op_r)
      mlsq_pkg::OP_CREATE: begin
        if (!req_valid_r) begin
          st_comb = mlsq_pkg::ST_NO_LIST;
        end else if (exists_r[req_idx_r]) begin
          st_comb = mlsq_pkg::ST_EXISTS;
        end else begin
          st_comb = mlsq_pkg::ST_OK;
        end
      end
      mlsq_pkg::OP_PUSH: begin
        if (!cur_exists) begin
          st_comb = mlsq_pkg::ST_NO_LIST;
        end else if (free_cnt_r == '0) begin
          st_comb = mlsq_pkg::ST_FULL;
        end else begin
          st_comb = mlsq_pkg::ST_OK;
        end
      end
      mlsq_pkg::OP_POP: begin
        if (!cur_exists) begin
          st_comb = mlsq_pkg::ST_NO_LIST;
        end else if (!cur_items) begin
          st_comb = mlsq_pkg::ST_EMPTY;
        end else begin
          st_comb = mlsq_pkg::ST_OK;
        end
      end
      default: begin
        st_comb = mlsq_pkg::ST_OK;
      end
    endcase
  end

  assign sts.need_mem  = (st_comb == mlsq_pkg::ST_OK) && (is_push || is_pop);
  assign sts.need_link = is_push && !cur_stack && cur_items;

  assign respond = (cmd.eval && !sts.need_mem) || (cmd.mem && !sts.need_link) || cmd.link;

  assign rd_addr = is_pop ? cur_head : free_head_r;

  // never-written link entries read as their reset value: next entry, wrapping
  assign link_rd = rd_vld_r ? link_rdata :
                   ((rd_idx_r == PW'(PD - 1)) ? '0 : rd_idx_r + 1'b1);

  always_comb begin
    link_we    = cmd.mem || cmd.link;
    link_waddr = e_r;
    link_wdata = '0;
    if (cmd.link) begin
      link_waddr = prev_tail_r;
      link_wdata = e_r;
    end else if (is_pop) begin
      link_wdata = free_head_r;
    end else if (cur_stack && cur_items) begin
      link_wdata = cur_head;
    end
  end

  assign val_we = cmd.mem && is_push;

  mlsq_ram #(.WIDTH(PW), .DEPTH(PD)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  mlsq_ram #(.WIDTH(DW), .DEPTH(PD)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (e_r),
    .wdata (req_val_r),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr;
    rd_vld_r <= link_vld_r[rd_addr];

    if (cmd.latch) begin
      req_op_r    <= in_op;
      req_valid_r <= (id_ext < XW'(NL));
      req_idx_r   <= id_ext[IW-1:0];
      req_stack_r <= in_make_stack;
      req_val_r   <= push_ext[DW-1:0];
    end

    if (cmd.eval) begin
      e_r         <= rd_addr;
      prev_tail_r <= cur_tail;
    end

    if (respond) begin
      out_status_r <= cmd.eval ? st_comb : mlsq_pkg::ST_OK;
      out_pop_r    <= (cmd.mem && is_pop) ? pop_ext[mlsq_pkg::VAL_W-1:0] : '0;
    end

    if (cmd.mem && is_push) begin
      if (!cur_items) begin
        head_r[req_idx_r] <= e_r;
        tail_r[req_idx_r] <= e_r;
      end else if (cur_stack) begin
        head_r[req_idx_r] <= e_r;
      end else begin
        tail_r[req_idx_r] <= e_r;
      end
    end

    if (cmd.mem && is_pop && (e_r != cur_tail)) begin
      head_r[req_idx_r] <= link_rd;
    end

    if (!rst_n) begin
      free_head_r <= '0;
      free_cnt_r  <= CW'(PD);
      for (int i = 0; i < NL; i++) begin
        exists_r[i] <= 1'b0;
        stack_r[i]  <= 1'b0;
        items_r[i]  <= 1'b0;
      end
      for (int j = 0; j < PD; j++) begin
        link_vld_r[j] <= 1'b0;
      end
    end else begin
      if (link_we) begin
        link_vld_r[link_waddr] <= 1'b1;
      end
      if (cmd.eval && (req_op_r == mlsq_pkg::OP_CREATE) && (st_comb == mlsq_pkg::ST_OK)) begin
        exists_r[req_idx_r] <= 1'b1;
        stack_r[req_idx_r]  <= req_stack_r;
        items_r[req_idx_r]  <= 1'b0;
      end
      if (cmd.mem && is_push) begin
        free_head_r         <= link_rd;
        free_cnt_r          <= free_cnt_r - 1'b1;
        items_r[req_idx_r]  <= 1'b1;
      end
      if (cmd.mem && is_pop) begin
        free_head_r <= e_r;
        if (free_cnt_r < CW'(PD)) begin
          free_cnt_r <= free_cnt_r + 1'b1;
        end
        if (e_r == cur_tail) begin
          items_r[req_idx_r] <= 1'b0;
        end
      end
    end
  end

  assign out_status       = out_status_r;
  assign out_popped_value = out_pop_r;

endmodule

### rtl/core/multi_list_stack_queue_engine_core.sv
// Steps: accept start in idle, evaluate; create, errors and op 3 end there;
//   pop, stack push and first push to a queue add a memory step; queue push adds
//   a link step. A new start is taken only once idle again; the steps follow from
//   the registered link RAM read and one write port (queue push: two link writes).
// Reset (rst_n low, synchronous): no lists, all 64 entries free, out_valid low.
// Results are strobed for one cycle; the receiver cannot stall.
module multi_list_stack_queue_engine_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mlsq_pkg::OP_W-1:0]         in_op,
  input  logic [mlsq_pkg::ID_W-1:0]         in_list_id,
  input  logic                              in_make_stack,
  input  logic signed [mlsq_pkg::VAL_W-1:0] in_push_value,
  output logic                              out_valid,
  output logic [mlsq_pkg::ST_W-1:0]         out_status,
  output logic signed [mlsq_pkg::VAL_W-1:0] out_popped_value
);

  mlsq_pkg::cmd_t cmd;
  mlsq_pkg::sts_t sts;

  mlsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mlsq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_list_id       (in_list_id),
    .in_make_stack    (in_make_stack),
    .in_push_value    (in_push_value),
    .out_status       (out_status),
    .out_popped_value (out_popped_value)
  );

endmodule

### rtl/core/mlsq_chk.sv
module mlsq_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [mlsq_pkg::OP_W-1:0]         in_op,
  input logic [mlsq_pkg::ID_W-1:0]         in_list_id,
  input logic                              in_make_stack,
  input logic signed [mlsq_pkg::VAL_W-1:0] in_push_value,
  input logic                              out_valid,
  input logic [mlsq_pkg::ST_W-1:0]         out_status,
  input logic signed [mlsq_pkg::VAL_W-1:0] out_popped_value
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("transaction finished without a result strobe");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result strobe while busy or repeated");

  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != mlsq_pkg::ST_OK)) |-> (out_popped_value == '0))
    else $error("failed transaction returned a nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == mlsq_pkg::ST_OK || out_status == mlsq_pkg::ST_EXISTS ||
                   out_status == mlsq_pkg::ST_NO_LIST || out_status == mlsq_pkg::ST_EMPTY ||
                   out_status == mlsq_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

bind multi_list_stack_queue_engine_core mlsq_chk u_mlsq_chk (.*);
